>>> design/dtq_pkg.sv
package dtq_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_BATCH_DEF   = 64;
    localparam int TIME_WIDTH_DEF  = 48;

    // field widths
    localparam int OP_W    = 3;
    localparam int KIND_W  = 3;
    localparam int ID_W    = 32;
    localparam int DELAY_W = 32;
    localparam int OWNER_W = 8;
    localparam int MDL_W   = 48;
    localparam int LIM_W   = 7;

    // batch limit after reset
    localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

    // request opcodes
    localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
    localparam logic [OP_W-1:0] OP_CANCEL     = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_MAINT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CANCEL_MNT = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ISSUED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONFLICT = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_PUSH,
        S_REM_RD,
        S_REM_WR,
        S_FINISH
    } t_state;

endpackage

>>> design/deadline_timeout_queue.sv
// deadline_timeout_queue: table of pending deadlines, earliest first
// request channel: i_in_valid / o_in_stall with opcode, delay, id, owner and
// maintenance deadline; one request is worked on at a time
// result channel: o_out_valid / i_out_stall; every request gives one or more
// results, the final one marked by o_last
// config channel: i_cfg_valid / o_cfg_ready writes the batch limit
// schedule, set and cancel maintenance go from decode straight to the result;
// the sequencer is back in idle when that result is registered
// cancel scans the entry memory at one read a cycle and, when the id is found,
// reads the last entry and writes it back into the hole
// tick advances the time, then scans once per expired id, up to the batch
// limit, removing each as cancel does; a held id is sent before the next is
// taken, and a scan that ends on an entry not yet due ends the batch
// reset clears the count, time and maintenance owner and sets the id counter
// to 1; the memory needs no clearing as only entries below the count are read
// when the receiver stalls, the held result stays and the sequencer waits
module deadline_timeout_queue #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_BATCH   = dtq_pkg::MAX_BATCH_DEF,
    parameter int TIME_WIDTH  = dtq_pkg::TIME_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [dtq_pkg::OP_W-1:0]    i_opcode,
    input  logic [dtq_pkg::DELAY_W-1:0] i_delay_ms,
    input  logic [dtq_pkg::ID_W-1:0]    i_event_id,
    input  logic [dtq_pkg::OWNER_W-1:0] i_owner_tag,
    input  logic [dtq_pkg::MDL_W-1:0]   i_maint_deadline,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dtq_pkg::KIND_W-1:0]  o_kind,
    output logic [dtq_pkg::ID_W-1:0]    o_id_out,
    output logic                        o_cancel_found,
    output logic                        o_maintenance_fired,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dtq_pkg::LIM_W-1:0]   i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = $clog2(MAX_BATCH + 1);
    localparam int TW = TIME_WIDTH;
    localparam int EW = TW + dtq_pkg::ID_W;
    localparam logic [TW-1:0] NEVER = {TW{1'b1}};
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // entry memory: deadline in the upper bits, id in the lower
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    dtq_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_count, n_count;
    logic [dtq_pkg::ID_W-1:0]     r_next_id, n_next_id;
    logic [TW-1:0]                r_now, n_now;
    logic [TW-1:0]                r_mdue, n_mdue;
    logic [dtq_pkg::OWNER_W-1:0]  r_mowner, n_mowner;
    logic [dtq_pkg::LIM_W-1:0]    r_lim;

    // latched request
    logic [dtq_pkg::OP_W-1:0]     r_op;
    logic [dtq_pkg::DELAY_W-1:0]  r_delay;
    logic [dtq_pkg::ID_W-1:0]     r_evid;
    logic [dtq_pkg::OWNER_W-1:0]  r_owner;
    logic [TW-1:0]                r_mdl;

    // scan state
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_rvld, n_rvld;
    logic [AW-1:0]                r_ridx, n_ridx;
    logic                         r_bhit, n_bhit;
    logic [AW-1:0]                r_bidx, n_bidx;
    logic [TW-1:0]                r_bdl, n_bdl;
    logic [dtq_pkg::ID_W-1:0]     r_bid, n_bid;

    // tick batch state
    logic [NW-1:0]                r_n, n_n;
    logic                         r_hold, n_hold;
    logic [dtq_pkg::ID_W-1:0]     r_hold_id, n_hold_id;

    // final result of non-tick requests
    logic [dtq_pkg::KIND_W-1:0]   r_fk, n_fk;
    logic [dtq_pkg::ID_W-1:0]     r_fid, n_fid;
    logic                         r_ffound, n_ffound;

    // output register
    logic                         r_out_valid;
    logic [dtq_pkg::KIND_W-1:0]   r_kind;
    logic [dtq_pkg::ID_W-1:0]     r_id_out;
    logic                         r_found, r_fired, r_last;

    logic                         emit;
    logic [dtq_pkg::KIND_W-1:0]   e_kind;
    logic [dtq_pkg::ID_W-1:0]     e_id;
    logic                         e_found, e_fired, e_last;

    logic                         out_free;
    logic                         in_acc;
    logic [NW-1:0]                eff_lim;
    logic [TW-1:0]                d_dl;
    logic [dtq_pkg::ID_W-1:0]     d_id;
    logic [TW-1:0]                room;
    logic [TW-1:0]                sched_dl;
    logic                         maint_hit;

    assign o_in_stall  = (r_state != dtq_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid         = r_out_valid;
    assign o_kind              = r_kind;
    assign o_id_out            = r_id_out;
    assign o_cancel_found      = r_found;
    assign o_maintenance_fired = r_fired;
    assign o_last              = r_last;

    // effective batch limit
    always_comb begin
        if (r_lim == '0) begin
            eff_lim = NW'(1);
        end else if (32'(r_lim) > 32'(MAX_BATCH)) begin
            eff_lim = NW'(MAX_BATCH);
        end else begin
            eff_lim = NW'(r_lim);
        end
    end

    // saturating deadline for schedule
    assign room     = NEVER - r_now;
    assign sched_dl = (64'(r_delay) >= 64'(room)) ? NEVER : (r_now + TW'(r_delay));

    assign d_dl = r_rd_data[EW-1:dtq_pkg::ID_W];
    assign d_id = r_rd_data[dtq_pkg::ID_W-1:0];

    assign maint_hit = (r_mowner != '0) && (r_mdue <= r_now);

    // entry memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_now     = r_now;
        n_mdue    = r_mdue;
        n_mowner  = r_mowner;
        n_idx     = r_idx;
        n_rvld    = 1'b0;
        n_ridx    = r_ridx;
        n_bhit    = r_bhit;
        n_bidx    = r_bidx;
        n_bdl     = r_bdl;
        n_bid     = r_bid;
        n_n       = r_n;
        n_hold    = r_hold;
        n_hold_id = r_hold_id;
        n_fk      = r_fk;
        n_fid     = r_fid;
        n_ffound  = r_ffound;
        rd_addr   = r_idx[AW-1:0];
        we        = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = {sched_dl, r_next_id};
        emit      = 1'b0;
        e_kind    = r_fk;
        e_id      = r_fid;
        e_found   = r_ffound;
        e_fired   = 1'b0;
        e_last    = 1'b1;

        // compare the entry read last cycle against the best so far
        if (r_rvld) begin
            if (r_op == dtq_pkg::OP_CANCEL) begin
                if (d_id == r_evid && (!r_bhit || d_dl < r_bdl)) begin
                    n_bhit = 1'b1;
                    n_bidx = r_ridx;
                    n_bdl  = d_dl;
                    n_bid  = d_id;
                end
            end else begin
                if (!r_bhit || d_dl < r_bdl || (d_dl == r_bdl && d_id < r_bid)) begin
                    n_bhit = 1'b1;
                    n_bidx = r_ridx;
                    n_bdl  = d_dl;
                    n_bid  = d_id;
                end
            end
        end

        case (r_state)
            dtq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = dtq_pkg::S_DECODE;
                end
            end
            dtq_pkg::S_DECODE: begin
                n_fk     = dtq_pkg::KIND_DONE;
                n_fid    = '0;
                n_ffound = 1'b0;
                n_idx    = '0;
                n_bhit   = 1'b0;
                n_n      = '0;
                n_hold   = 1'b0;
                n_state  = dtq_pkg::S_FINISH;
                case (r_op)
                    dtq_pkg::OP_SCHEDULE: begin
                        if (r_count >= DEPTH_C) begin
                            n_fk = dtq_pkg::KIND_FULL;
                        end else begin
                            we        = 1'b1;
                            n_count   = r_count + CW'(1);
                            n_fk      = dtq_pkg::KIND_ISSUED;
                            n_fid     = r_next_id;
                            n_next_id = (r_next_id + 1'b1 == '0) ? dtq_pkg::ID_W'(1)
                                                                 : r_next_id + 1'b1;
                        end
                    end
                    dtq_pkg::OP_CANCEL: begin
                        if (r_evid != '0 && r_count != '0) begin
                            n_state = dtq_pkg::S_SCAN;
                        end
                    end
                    dtq_pkg::OP_TICK: begin
                        if (r_now < NEVER - TW'(1)) begin
                            n_now = r_now + TW'(1);
                        end
                        if (r_count != '0) begin
                            n_state = dtq_pkg::S_SCAN;
                        end
                    end
                    dtq_pkg::OP_SET_MAINT: begin
                        if (r_owner == '0 || (r_mowner != '0 && r_mowner != r_owner)) begin
                            n_fk = dtq_pkg::KIND_CONFLICT;
                        end else begin
                            n_mowner = r_owner;
                            n_mdue   = r_mdl;
                        end
                    end
                    dtq_pkg::OP_CANCEL_MNT: begin
                        if (r_mowner == r_owner) begin
                            n_mowner = '0;
                            n_mdue   = NEVER;
                        end
                    end
                    default: begin
                        n_fk = dtq_pkg::KIND_DONE;
                    end
                endcase
            end
            // issue one read a cycle over the live entries
            dtq_pkg::S_SCAN: begin
                rd_addr = r_idx[AW-1:0];
                n_rvld  = 1'b1;
                n_ridx  = r_idx[AW-1:0];
                n_idx   = r_idx + CW'(1);
                if (r_idx == r_count - CW'(1)) begin
                    n_state = dtq_pkg::S_SCAN_END;
                end
            end
            dtq_pkg::S_SCAN_END: begin
                n_state = dtq_pkg::S_DECIDE;
            end
            dtq_pkg::S_DECIDE: begin
                if (r_op == dtq_pkg::OP_CANCEL) begin
                    n_state = r_bhit ? dtq_pkg::S_REM_RD : dtq_pkg::S_FINISH;
                end else if (r_bdl > r_now) begin
                    n_state = dtq_pkg::S_FINISH;
                end else if (r_hold) begin
                    n_state = dtq_pkg::S_PUSH;
                end else begin
                    n_hold    = 1'b1;
                    n_hold_id = r_bid;
                    n_state   = dtq_pkg::S_REM_RD;
                end
            end
            // send the held expired id before taking the new one
            dtq_pkg::S_PUSH: begin
                emit    = 1'b1;
                e_kind  = dtq_pkg::KIND_EXPIRED;
                e_id    = r_hold_id;
                e_found = 1'b0;
                e_last  = 1'b0;
                if (out_free) begin
                    n_hold_id = r_bid;
                    n_state   = dtq_pkg::S_REM_RD;
                end
            end
            dtq_pkg::S_REM_RD: begin
                rd_addr = AW'(r_count - CW'(1));
                n_state = dtq_pkg::S_REM_WR;
            end
            // move the last entry into the removed slot
            dtq_pkg::S_REM_WR: begin
                we       = 1'b1;
                wr_addr  = r_bidx;
                wr_data  = r_rd_data;
                n_count  = r_count - CW'(1);
                n_idx    = '0;
                n_bhit   = 1'b0;
                if (r_op == dtq_pkg::OP_CANCEL) begin
                    n_ffound = 1'b1;
                    n_state  = dtq_pkg::S_FINISH;
                end else begin
                    n_n = r_n + NW'(1);
                    if (r_n + NW'(1) < eff_lim && r_count != CW'(1)) begin
                        n_state = dtq_pkg::S_SCAN;
                    end else begin
                        n_state = dtq_pkg::S_FINISH;
                    end
                end
            end
            dtq_pkg::S_FINISH: begin
                emit = 1'b1;
                if (r_op == dtq_pkg::OP_TICK) begin
                    e_kind  = r_hold ? dtq_pkg::KIND_EXPIRED : dtq_pkg::KIND_DONE;
                    e_id    = r_hold ? r_hold_id : '0;
                    e_found = 1'b0;
                    e_fired = maint_hit;
                end
                if (out_free) begin
                    n_hold  = 1'b0;
                    n_state = dtq_pkg::S_IDLE;
                    if (r_op == dtq_pkg::OP_TICK && maint_hit) begin
                        n_mdue = NEVER;
                    end
                end
            end
            default: begin
                n_state = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dtq_pkg::S_IDLE;
            r_count   <= '0;
            r_next_id <= dtq_pkg::ID_W'(1);
            r_now     <= '0;
            r_mdue    <= NEVER;
            r_mowner  <= '0;
            r_lim     <= dtq_pkg::LIM_RESET;
            r_rvld    <= 1'b0;
            r_hold    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_now     <= n_now;
            r_mdue    <= n_mdue;
            r_mowner  <= n_mowner;
            r_rvld    <= n_rvld;
            r_hold    <= n_hold;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lim <= i_cfg_data;
            end
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_opcode;
            r_delay <= i_delay_ms;
            r_evid  <= i_event_id;
            r_owner <= i_owner_tag;
            r_mdl   <= TW'(i_maint_deadline);
        end
        r_idx     <= n_idx;
        r_ridx    <= n_ridx;
        r_bhit    <= n_bhit;
        r_bidx    <= n_bidx;
        r_bdl     <= n_bdl;
        r_bid     <= n_bid;
        r_n       <= n_n;
        r_hold_id <= n_hold_id;
        r_fk      <= n_fk;
        r_fid     <= n_fid;
        r_ffound  <= n_ffound;
        if (emit && out_free) begin
            r_kind   <= e_kind;
            r_id_out <= e_id;
            r_found  <= e_found;
            r_fired  <= e_fired;
            r_last   <= e_last;
        end
    end

`ifndef SYNTHESIS
    // table never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    // a removal always has an entry to take
    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtq_pkg::S_REM_WR |-> r_count != '0)
        else $error("removal from empty table");

    // a tick never reports more than the batch limit
    a_batch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dtq_pkg::S_FINISH |-> r_n <= eff_lim)
        else $error("batch limit exceeded");

    // an accepted request blocks the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second request taken while busy");
`endif

endmodule
